// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PCPA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle property failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define PCPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle property failed");

`endif

// ===== src/pcpa_pkg.sv =====
package pcpa_pkg;

    localparam int CPU_COUNT   = 8;
    localparam int STEAL_COUNT = 1024;
    localparam int PAGE_COUNT  = 32768;
    localparam int PAGE_BYTES  = 4096;

    localparam int CPU_W      = 3;
    localparam int ADDR_W     = 32;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int SLOT_W     = $clog2(PAGE_COUNT);
    localparam int LINK_W     = SLOT_W + 1;
    localparam int COUNT_W    = $clog2(STEAL_COUNT + 2);
    localparam int QUOT_W     = ADDR_W + 2 - PAGE_SHIFT;

    localparam logic [COUNT_W-1:0] STEAL_LIMIT = COUNT_W'(STEAL_COUNT + 1);

    localparam logic [ADDR_W-1:0] MEM_BASE_RST = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] MEM_TOP_RST  = 32'h8800_0000;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_TOP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK,
        ST_OOM,
        ST_BAD_FREE
    } t_status;

    typedef enum logic {
        REQ_ALLOC,
        REQ_FREE
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_POP,
        S_WALK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
    } t_chk;

    typedef struct packed {
        logic              vld;
        logic [SLOT_W-1:0] slot;
    } t_link;

endpackage

// ===== src/pcpa_ram.sv =====
module pcpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/pcpa_addr_chk.sv =====
module pcpa_addr_chk (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pcpa_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pcpa_pkg::ADDR_W-1:0]        i_cfg_data,
    input  logic [pcpa_pkg::ADDR_W-1:0]        i_page_addr,
    input  logic [pcpa_pkg::SLOT_W-1:0]        i_slot,
    output pcpa_pkg::t_chk                     o_chk,
    output logic [pcpa_pkg::ADDR_W-1:0]        o_slot_addr
);
    import pcpa_pkg::*;

    logic [ADDR_W-1:0] r_mem_base;
    logic [ADDR_W-1:0] r_mem_top;
    logic [ADDR_W:0]   r_ab;
    logic [ADDR_W:0]   n_ab;
    logic [ADDR_W+1:0] diff;
    logic [QUOT_W-1:0] quot;

    always_comb begin
        n_ab = {1'b0, i_cfg_data[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
        if (|i_cfg_data[PAGE_SHIFT-1:0]) begin
            n_ab = n_ab + (ADDR_W+1)'(PAGE_BYTES);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_base <= MEM_BASE_RST;
            r_mem_top  <= MEM_TOP_RST;
            r_ab       <= {1'b0, MEM_BASE_RST};
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_MEM_BASE) begin
                r_mem_base <= i_cfg_data;
                r_ab       <= n_ab;
            end
            if (i_cfg_we && i_cfg_idx == CFG_MEM_TOP) begin
                r_mem_top <= i_cfg_data;
            end
        end
    end

    assign diff = {2'b00, i_page_addr} - {1'b0, r_ab};
    assign quot = diff[ADDR_W+1:PAGE_SHIFT];

    assign o_chk.ok = (i_page_addr[PAGE_SHIFT-1:0] == '0) && (i_page_addr >= r_mem_base)
                      && (i_page_addr < r_mem_top) && (quot < QUOT_W'(PAGE_COUNT));
    assign o_chk.slot = quot[SLOT_W-1:0];

    assign o_slot_addr = r_ab[ADDR_W-1:0]
                         + {{(ADDR_W-SLOT_W-PAGE_SHIFT){1'b0}}, i_slot, {PAGE_SHIFT{1'b0}}};

endmodule

// ===== src/per_cpu_page_allocator_with_steal_top.sv =====
// Per-CPU page allocator with stealing. One request beat enters on the input channel
// (i_valid/o_ready) and exactly one result beat leaves on the output channel
// (o_valid/i_ready). A free pushes the page on the requester's list or reports a
// bad address; an allocate pops the requester's head, or steals from the lowest
// numbered CPU whose list is not empty, or reports out-of-memory.
// Heads live in flip-flops; the next-slot links live in a single-port-read,
// single-port-write synchronous RAM with a registered read port.
// A free goes from the decode state straight to the output state; a local allocate
// goes through the decode and pop states first. The result beat leaves when i_ready is
// high, and the next request is taken once the block has returned to idle.
// A steal whose victim list goes on past the popped page then walks that list in the
// walk state, each step waiting for the RAM read, and moves at most STEAL_COUNT + 1 pages.
// One request is in flight at a time; o_ready is high only when idle.
// When the receiver stalls, the result beat is held and no new request is taken.
// Reset clears every list head and restores the base and top registers;
// the link RAM needs no clearing since only entries written by a free are read.
// Configuration writes take effect at once and should be issued while idle.
module per_cpu_page_allocator_with_steal_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pcpa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pcpa_pkg::ADDR_W-1:0]    i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_req_type,
    input  logic [pcpa_pkg::CPU_W-1:0]     i_cpu_id,
    input  logic [pcpa_pkg::ADDR_W-1:0]    i_page_addr,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [pcpa_pkg::ADDR_W-1:0]    o_alloc_addr,
    output logic [1:0]                     o_status
);
    import pcpa_pkg::*;

    t_state             r_state, n_state;
    t_req               r_req, n_req;
    logic [CPU_W-1:0]   r_cpu, n_cpu;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [CPU_W-1:0]   r_vic, n_vic;
    logic               r_steal, n_steal;
    logic [SLOT_W-1:0]  r_first, n_first;
    logic [SLOT_W-1:0]  r_cur, n_cur;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [ADDR_W-1:0]  r_res_addr, n_res_addr;
    t_status            r_status, n_status;
    logic [SLOT_W-1:0]  r_head_slot [CPU_COUNT];
    logic [SLOT_W-1:0]  n_head_slot [CPU_COUNT];
    logic               r_head_vld  [CPU_COUNT];
    logic               n_head_vld  [CPU_COUNT];

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    t_link             ram_wdata;
    logic [SLOT_W-1:0] ram_raddr;
    t_link             ram_rdata;

    t_chk              chk;
    logic [ADDR_W-1:0] slot_addr;
    logic [SLOT_W-1:0] pop_slot;
    logic              cpu_ok;
    logic              vic_found;
    logic [CPU_W-1:0]  vic_idx;

    pcpa_addr_chk u_addr_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_page_addr (r_addr),
        .i_slot      (pop_slot),
        .o_chk       (chk),
        .o_slot_addr (slot_addr)
    );

    pcpa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (PAGE_COUNT)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cpu_ok = (32'(r_cpu) < CPU_COUNT);

    always_comb begin
        vic_found = 1'b0;
        vic_idx   = '0;
        for (int v = CPU_COUNT - 1; v >= 0; v--) begin
            if (r_head_vld[v] && CPU_W'(v) != r_cpu) begin
                vic_found = 1'b1;
                vic_idx   = CPU_W'(v);
            end
        end
    end

    assign pop_slot = r_head_vld[r_cpu] ? r_head_slot[r_cpu] : r_head_slot[vic_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int c = 0; c < CPU_COUNT; c++) begin
                r_head_vld[c] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            for (int c = 0; c < CPU_COUNT; c++) begin
                r_head_vld[c] <= n_head_vld[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_cpu      <= n_cpu;
        r_addr     <= n_addr;
        r_vic      <= n_vic;
        r_steal    <= n_steal;
        r_first    <= n_first;
        r_cur      <= n_cur;
        r_count    <= n_count;
        r_res_addr <= n_res_addr;
        r_status   <= n_status;
        for (int c = 0; c < CPU_COUNT; c++) begin
            r_head_slot[c] <= n_head_slot[c];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_cpu      = r_cpu;
        n_addr     = r_addr;
        n_vic      = r_vic;
        n_steal    = r_steal;
        n_first    = r_first;
        n_cur      = r_cur;
        n_count    = r_count;
        n_res_addr = r_res_addr;
        n_status   = r_status;
        for (int c = 0; c < CPU_COUNT; c++) begin
            n_head_slot[c] = r_head_slot[c];
            n_head_vld[c]  = r_head_vld[c];
        end
        ram_we    = 1'b0;
        ram_waddr = r_cur;
        ram_wdata = '0;
        ram_raddr = pop_slot;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req   = t_req'(i_req_type);
                    n_cpu   = i_cpu_id;
                    n_addr  = i_page_addr;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res_addr = '0;
                n_state    = S_OUT;
                if (r_req == REQ_FREE) begin
                    if (!cpu_ok || !chk.ok) begin
                        n_status = ST_BAD_FREE;
                    end else begin
                        n_status  = ST_OK;
                        ram_we    = 1'b1;
                        ram_waddr = chk.slot;
                        ram_wdata = '{vld: r_head_vld[r_cpu], slot: r_head_slot[r_cpu]};
                        n_head_slot[r_cpu] = chk.slot;
                        n_head_vld[r_cpu]  = 1'b1;
                    end
                end else begin
                    n_status = ST_OOM;
                    if (cpu_ok && (r_head_vld[r_cpu] || vic_found)) begin
                        n_status   = ST_OK;
                        n_res_addr = slot_addr;
                        n_vic      = r_head_vld[r_cpu] ? r_cpu : vic_idx;
                        n_steal    = !r_head_vld[r_cpu];
                        n_state    = S_POP;
                    end
                end
            end
            S_POP: begin
                if (ram_rdata.vld) begin
                    n_head_slot[r_vic] = ram_rdata.slot;
                end else begin
                    n_head_vld[r_vic] = 1'b0;
                end
                if (r_steal && ram_rdata.vld) begin
                    n_first   = ram_rdata.slot;
                    n_cur     = ram_rdata.slot;
                    n_count   = COUNT_W'(1);
                    ram_raddr = ram_rdata.slot;
                    n_state   = S_WALK;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_WALK: begin
                if (r_count < STEAL_LIMIT && ram_rdata.vld) begin
                    n_cur     = ram_rdata.slot;
                    n_count   = r_count + COUNT_W'(1);
                    ram_raddr = ram_rdata.slot;
                end else begin
                    if (ram_rdata.vld) begin
                        n_head_slot[r_vic] = ram_rdata.slot;
                    end else begin
                        n_head_vld[r_vic] = 1'b0;
                    end
                    ram_we    = 1'b1;
                    ram_waddr = r_cur;
                    ram_wdata = '{vld: 1'b0, slot: ram_rdata.slot};
                    n_head_slot[r_cpu] = r_first;
                    n_head_vld[r_cpu]  = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = (r_state == S_OUT);
    assign o_alloc_addr = r_res_addr;
    assign o_status     = r_status;

endmodule

// ===== src/pcpa_chk.sv =====
`include "assert_macros.svh"

module pcpa_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_ready,
    input logic                           i_req_type,
    input logic [pcpa_pkg::CPU_W-1:0]     i_cpu_id,
    input logic [pcpa_pkg::ADDR_W-1:0]    i_page_addr,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic [pcpa_pkg::ADDR_W-1:0]    o_alloc_addr,
    input logic [1:0]                     o_status
);
    import pcpa_pkg::*;

    `PCPA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_alloc_addr) && $stable(o_status))
    `PCPA_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && !o_ready,
        i_valid && $stable(i_req_type) && $stable(i_cpu_id) && $stable(i_page_addr))
    `PCPA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready,
        !o_ready && !o_valid)
    `PCPA_ASSERT_SAME(a_one_in_flight, i_clk, i_rst_n, o_valid, !o_ready)
    `PCPA_ASSERT_SAME(a_fail_addr_zero, i_clk, i_rst_n, o_valid && o_status != ST_OK,
        o_alloc_addr == '0)

endmodule

bind per_cpu_page_allocator_with_steal_top pcpa_chk u_pcpa_chk (.*);

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pcpa_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct {
        t_req              kind;
        logic [CPU_W-1:0]  cpu;
        logic [ADDR_W-1:0] addr;
    } t_page_req;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        t_status           status;
    } t_page_resp;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx    = CFG_MEM_BASE;
    logic [ADDR_W-1:0]    cfg_data   = '0;
    logic                 req_valid  = 1'b0;
    logic                 req_ready;
    logic                 req_type   = 1'b0;
    logic [CPU_W-1:0]     req_cpu    = '0;
    logic [ADDR_W-1:0]    req_addr   = '0;
    logic                 rsp_valid;
    logic                 rsp_ready  = 1'b0;
    logic [ADDR_W-1:0]    rsp_addr;
    logic [1:0]           rsp_status;

    // Shadow copy of the allocator state.
    logic [ADDR_W-1:0] cfg_base = MEM_BASE_RST;
    logic [ADDR_W-1:0] cfg_top  = MEM_TOP_RST;
    bit [SLOT_W-1:0]   head_slot [CPU_COUNT];
    bit                head_vld  [CPU_COUNT];
    bit [SLOT_W-1:0]   next_slot [PAGE_COUNT];
    bit                next_vld  [PAGE_COUNT];

    t_page_req  req_fifo[$];
    t_page_resp expected_pages[$];

    int fail_count    = 0;
    int results_seen  = 0;
    int n_requests    = 0;
    int n_handed_out  = 0;
    int n_stolen      = 0;
    int n_oom         = 0;
    int n_returned    = 0;
    int n_rejected    = 0;
    int n_reg_writes  = 0;
    int gap_left      = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    bit tx_quiet      = 1'b0;
    bit rx_quiet      = 1'b0;
    bit long_hold_done = 1'b0;
    t_page_req  next_beat;
    t_page_resp want;

    per_cpu_page_allocator_with_steal_top dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_valid      (req_valid),
        .o_ready      (req_ready),
        .i_req_type   (req_type),
        .i_cpu_id     (req_cpu),
        .i_page_addr  (req_addr),
        .o_valid      (rsp_valid),
        .i_ready      (rsp_ready),
        .o_alloc_addr (rsp_addr),
        .o_status     (rsp_status)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint unsigned aligned_base();
        longint unsigned b;
        b = cfg_base;
        if (b % PAGE_BYTES != 0) begin
            b = b + (PAGE_BYTES - b % PAGE_BYTES);
        end
        return b;
    endfunction

    function automatic logic [ADDR_W-1:0] page_of_slot(input longint unsigned slot);
        return ADDR_W'(aligned_base() + slot * PAGE_BYTES);
    endfunction

    function automatic int unsigned take_head(input int c);
        int unsigned s;
        s = head_slot[c];
        if (next_vld[s]) begin
            head_slot[c] = next_slot[s];
        end else begin
            head_vld[c] = 1'b0;
        end
        return s;
    endfunction

    function automatic t_page_resp predict_page_result(input t_req kind,
                                                       input logic [CPU_W-1:0] cpu,
                                                       input logic [ADDR_W-1:0] addr);
        t_page_resp      r;
        longint unsigned ab;
        longint unsigned a;
        longint unsigned slot;
        int unsigned     taken;
        int unsigned     first;
        int unsigned     cur;
        int unsigned     walked;
        r.addr   = '0;
        r.status = ST_OK;
        ab = aligned_base();
        a  = addr;
        n_requests++;
        if (kind == REQ_FREE) begin
            slot = (a >= ab) ? (a - ab) / PAGE_BYTES : 0;
            if (cpu >= CPU_COUNT || a % PAGE_BYTES != 0 || a < cfg_base || a >= cfg_top ||
                a < ab || slot >= PAGE_COUNT) begin
                r.status = ST_BAD_FREE;
                n_rejected++;
                return r;
            end
            next_slot[slot] = head_slot[cpu];
            next_vld[slot]  = head_vld[cpu];
            head_slot[cpu]  = SLOT_W'(slot);
            head_vld[cpu]   = 1'b1;
            n_returned++;
            return r;
        end
        if (cpu >= CPU_COUNT) begin
            r.status = ST_OOM;
            n_oom++;
            return r;
        end
        if (head_vld[cpu]) begin
            r.addr = page_of_slot(take_head(cpu));
            n_handed_out++;
            return r;
        end
        for (int v = 0; v < CPU_COUNT; v++) begin
            if (v == cpu || !head_vld[v]) continue;
            taken = take_head(v);
            r.addr = page_of_slot(taken);
            n_handed_out++;
            n_stolen++;
            if (!head_vld[v]) return r;
            first  = head_slot[v];
            cur    = first;
            walked = 1;
            while (walked < STEAL_COUNT + 1 && next_vld[cur]) begin
                cur = next_slot[cur];
                walked++;
            end
            if (next_vld[cur]) begin
                head_slot[v] = next_slot[cur];
            end else begin
                head_vld[v] = 1'b0;
            end
            next_vld[cur]  = 1'b0;
            head_slot[cpu] = SLOT_W'(first);
            head_vld[cpu]  = 1'b1;
            return r;
        end
        r.status = ST_OOM;
        n_oom++;
        return r;
    endfunction

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Request driver: a beat stays on the bus until accepted, then an optional gap follows.
    always @(posedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
        end else begin
            if (req_valid && req_ready) begin
                expected_pages.push_back(predict_page_result(t_req'(req_type), req_cpu,
                                                             req_addr));
            end
            if (!req_valid || req_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    req_valid <= 1'b0;
                end else if (req_fifo.size() != 0) begin
                    next_beat = req_fifo.pop_front();
                    req_type  <= next_beat.kind;
                    req_cpu   <= next_beat.cpu;
                    req_addr  <= next_beat.addr;
                    req_valid <= 1'b1;
                    if ($urandom_range(0, 99) < 2) tx_quiet = !tx_quiet;
                    gap_left = tx_quiet ? 0 : pick_pause();
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver back-pressure.
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_ready <= 1'b0;
        end else begin
            if (rsp_valid && rsp_ready) begin
                results_seen++;
                if (expected_pages.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result beat: addr %h status %0d",
                                 rsp_addr, rsp_status);
                    end
                end else begin
                    want = expected_pages.pop_front();
                    if (rsp_addr !== want.addr || rsp_status !== want.status) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display({"mismatch on result %0d: expected addr %h status %0d,",
                                      " got addr %h status %0d"},
                                     results_seen, want.addr, want.status, rsp_addr,
                                     rsp_status);
                        end
                    end
                end
            end
            if ($urandom_range(0, 99) < 1) rx_quiet = !rx_quiet;
            if (hold_left != 0) begin
                hold_left--;
                rsp_ready <= 1'b0;
            end else if (!long_hold_done && results_seen >= 300) begin
                long_hold_done = 1'b1;
                hold_left = 500;
                rsp_ready <= 1'b0;
            end else if (rx_quiet) begin
                rsp_ready <= 1'b1;
            end else begin
                hold_left = pick_pause();
                if (hold_left == 0) begin
                    rsp_ready <= 1'b1;
                end else begin
                    hold_left--;
                    rsp_ready <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_beat(input t_req kind, input int cpu, input logic [ADDR_W-1:0] addr);
        t_page_req b;
        b.kind = kind;
        b.cpu  = CPU_W'(cpu);
        b.addr = addr;
        req_fifo.push_back(b);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
        if (idx == CFG_MEM_BASE) begin
            cfg_base = value;
        end else begin
            cfg_top = value;
        end
        n_reg_writes++;
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic drain();
        while (req_fifo.size() != 0 || req_valid || expected_pages.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_mixed(input int count, input int free_pct, input int pool);
        t_page_req       b;
        longint unsigned ab;
        int              r;
        ab = aligned_base();
        repeat (count) begin
            b.kind = REQ_ALLOC;
            b.cpu  = CPU_W'($urandom_range(0, CPU_COUNT - 1));
            b.addr = $urandom;
            if ($urandom_range(0, 99) < free_pct) begin
                b.kind = REQ_FREE;
                if ($urandom_range(0, 1) == 1) b.cpu = CPU_W'($urandom_range(0, 2));
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    b.addr = ADDR_W'(ab + longint'($urandom_range(0, pool - 1)) * PAGE_BYTES);
                end else if (r < 88) begin
                    case ($urandom_range(0, 4))
                        0: b.addr = cfg_top;
                        1: b.addr = cfg_top - PAGE_BYTES;
                        2: b.addr = cfg_base;
                        3: b.addr = ADDR_W'(ab + longint'(PAGE_COUNT) * PAGE_BYTES);
                        default: b.addr = ADDR_W'(ab + longint'(PAGE_COUNT - 1) * PAGE_BYTES);
                    endcase
                end else if (r < 95) begin
                    b.addr = b.addr & ~ADDR_W'(PAGE_BYTES - 1);
                end
            end
            req_fifo.push_back(b);
        end
    endtask

    // A list longer than the steal window on CPU 0, then a steal by a CPU with an empty list.
    task automatic queue_long_steal();
        longint unsigned ab;
        int              thief;
        ab = aligned_base();
        thief = CPU_COUNT - 1;
        for (int c = 1; c < CPU_COUNT; c++) begin
            if (!head_vld[c]) thief = c;
        end
        for (int i = 0; i < STEAL_COUNT + 16; i++) begin
            add_beat(REQ_FREE, 0, ADDR_W'(ab + longint'(i) * PAGE_BYTES));
        end
        add_beat(REQ_ALLOC, thief, $urandom);
        repeat (20) add_beat(REQ_ALLOC, thief, $urandom);
        repeat (20) add_beat(REQ_ALLOC, 0, $urandom);
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        add_beat(REQ_ALLOC, 0, 32'h0000_0000);
        add_beat(REQ_FREE,  0, 32'h8000_0000);
        add_beat(REQ_FREE,  0, 32'h87FF_F000);
        add_beat(REQ_FREE,  1, 32'h8800_0000);
        add_beat(REQ_FREE,  1, 32'h7FFF_F000);
        add_beat(REQ_FREE,  2, 32'h8000_0800);
        add_beat(REQ_FREE,  3, 32'h0000_0000);
        add_beat(REQ_FREE,  7, 32'hFFFF_FFFF);
        add_beat(REQ_FREE,  7, 32'hFFFF_F000);
        add_beat(REQ_ALLOC, 0, 32'hFFFF_FFFF);
        add_beat(REQ_FREE,  7, 32'h8000_1000);
        add_beat(REQ_FREE,  7, 32'h8000_2000);
        add_beat(REQ_FREE,  7, 32'h8000_3000);
        add_beat(REQ_ALLOC, 4, 32'h0000_0000);
        add_beat(REQ_ALLOC, 4, 32'h0000_0000);
        add_beat(REQ_ALLOC, 4, 32'h0000_0000);
        add_beat(REQ_FREE,  5, 32'h8000_5000);
        add_beat(REQ_FREE,  5, 32'h8000_5000);
        add_beat(REQ_ALLOC, 5, 32'h0000_0000);
        add_beat(REQ_ALLOC, 6, 32'h0000_0000);
        add_beat(REQ_ALLOC, 6, 32'h0000_0000);
        add_beat(REQ_ALLOC, 6, 32'h0000_0000);
        add_beat(REQ_ALLOC, 5, 32'h0000_0000);
        drain();

        queue_mixed(100, 50, PAGE_COUNT);
        drain();

        write_reg(CFG_MEM_BASE, 32'h0000_0000);
        write_reg(CFG_MEM_TOP,  32'hFFFF_FFFF);
        queue_mixed(200, 40, PAGE_COUNT);
        drain();

        write_reg(CFG_MEM_BASE, 32'h1234_5ABC);
        write_reg(CFG_MEM_TOP,  32'h1300_0000);
        queue_long_steal();
        queue_mixed(100, 50, 3300);
        drain();

        // Moving the base under populated lists makes returned addresses wrap.
        write_reg(CFG_MEM_BASE, 32'hFFFF_0000);
        write_reg(CFG_MEM_TOP,  32'hFFFF_FFFF);
        queue_mixed(200, 45, 16);
        drain();

        write_reg(CFG_MEM_BASE, 32'hFFFF_FFFF);
        write_reg(CFG_MEM_TOP,  32'h0000_0000);
        queue_mixed(100, 50, 16);
        drain();

        $display("run covered %0d requests: %0d pages handed out (%0d by stealing),",
                 n_requests, n_handed_out, n_stolen);
        $display("%0d out of memory, %0d pages returned, %0d frees rejected, %0d register writes",
                 n_oom, n_returned, n_rejected, n_reg_writes);
        if (fail_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule

// ===== per_cpu_page_allocator_with_steal_top.f =====
+incdir+src
src/pcpa_pkg.sv
src/pcpa_ram.sv
src/pcpa_addr_chk.sv
src/per_cpu_page_allocator_with_steal_top.sv
src/pcpa_chk.sv
tb/testbench.sv
